>>> hw/rtl/owb_pkg.sv
package owb_pkg;

  localparam int unsigned RING_W    = 11;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned RING_DEPTH_DEF = 1024;
  localparam int unsigned COEFF_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOP   = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [RING_W-1:0] RING_RST  = 11'd1024;
  localparam logic [RING_W-1:0] FRAME_RST = 11'd512;
  localparam logic [RING_W-1:0] HOP_RST   = 11'd256;

  typedef struct packed {
    logic load_query;
    logic hm_start;
    logic init_down;
    logic step_down;
    logic init_up;
    logic step_up;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic degenerate;
    logic hm_busy;
    logic down_ok;
    logic up_ok;
  } ctl_status_t;

endpackage

>>> hw/rtl/owb_ram.sv
module owb_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/owb_rem.sv
module owb_rem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [owb_pkg::RING_W-1:0] dividend_i,
  input  logic [owb_pkg::RING_W-1:0] divisor_i,
  output logic                       busy_o,
  output logic [owb_pkg::RING_W-1:0] rem_o
);

  localparam int unsigned W      = owb_pkg::RING_W;
  localparam int unsigned STEP_W = $clog2(W + 1);

  logic [STEP_W-1:0] cnt_q;
  logic [W-1:0]      rem_q;
  logic [W-1:0]      dvd_q;
  logic [W:0]        trial;
  logic [W-1:0]      rem_step;

  // Restoring remainder, one dividend bit per cycle, most significant first.
  assign trial = {rem_q, dvd_q[W-1]};

  always_comb begin
    if (trial >= {1'b0, divisor_i}) begin
      rem_step = W'(trial - {1'b0, divisor_i});
    end else begin
      rem_step = trial[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= STEP_W'(W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_step;
      dvd_q <= {dvd_q[W-2:0], 1'b0};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign rem_o  = rem_q;

endmodule

>>> hw/rtl/owb_datapath.sv
module owb_datapath #(
  parameter int unsigned RING_DEPTH = owb_pkg::RING_DEPTH_DEF,
  parameter int unsigned COEFF_BITS = owb_pkg::COEFF_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [owb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [owb_pkg::RING_W-1:0]    cfg_data_i,
  input  logic                          in_accept_i,
  input  logic                          command_i,
  input  logic [owb_pkg::POS_W-1:0]     position_i,
  input  logic [owb_pkg::COEF_W-1:0]    coefficient_i,
  input  owb_pkg::ctl_cmd_t             cmd_i,
  output owb_pkg::ctl_status_t          status_o,
  output logic [owb_pkg::POS_W-1:0]     norm_position_o,
  output logic [owb_pkg::VALUE_W-1:0]   norm_value_o
);

  localparam int unsigned AW  = $clog2(RING_DEPTH);
  localparam int unsigned RW  = owb_pkg::RING_W;
  localparam int unsigned PW  = owb_pkg::POS_W;
  localparam int unsigned CW  = owb_pkg::CNT_W;
  localparam int unsigned VW  = owb_pkg::VALUE_W;
  localparam int unsigned FW  = owb_pkg::COEF_W;

  logic [RW-1:0] ring_q, frame_q, hop_q;
  logic [RW-1:0] r_eff, n_eff, hm;
  logic          hm_busy;
  logic [PW-1:0] p_q;
  logic [RW-1:0] m_q, m_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] lim_down, lim_up;
  logic [RW-1:0] base;
  logic [RW:0]   add_s;
  logic [RW-1:0] add_m, sub_m;
  logic          rd_en, pend_q;
  logic          wr_en;
  logic [AW+RW-1:0]         raddr_wide;
  logic [AW+PW-1:0]         waddr_wide;
  logic [COEFF_BITS+FW-1:0] wdata_wide;
  logic [COEFF_BITS-1:0]    rdata;
  logic [VW:0]              sum_ext;
  logic [VW-1:0]            sum_q, sum_d;
  logic [PW-1:0]            norm_position_q;
  logic [VW-1:0]            norm_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q  <= owb_pkg::RING_RST;
      frame_q <= owb_pkg::FRAME_RST;
      hop_q   <= owb_pkg::HOP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        owb_pkg::CFG_RING:  ring_q  <= cfg_data_i;
        owb_pkg::CFG_FRAME: frame_q <= cfg_data_i;
        owb_pkg::CFG_HOP:   hop_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign r_eff = (32'(ring_q) > 32'(RING_DEPTH)) ? RW'(RING_DEPTH) : ring_q;
  assign n_eff = (frame_q > r_eff) ? r_eff : frame_q;

  assign lim_down = CW'(n_eff) + CW'(hop_q);
  assign lim_up   = CW'(r_eff) + CW'(n_eff) + CW'(hop_q) - CW'(1);

  assign status_o.degenerate = (r_eff == '0) || (n_eff == '0) || (hop_q == '0) ||
                               ({1'b0, p_q} >= r_eff);
  assign status_o.hm_busy    = hm_busy;
  assign status_o.down_ok    = (cnt_q < lim_down);
  assign status_o.up_ok      = (cnt_q < lim_up);

  owb_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.hm_start),
    .dividend_i (hop_q),
    .divisor_i  (r_eff),
    .busy_o     (hm_busy),
    .rem_o      (hm)
  );

  // Descending placements add hop mod ring to the index, ascending ones subtract it.
  assign base  = cmd_i.init_down ? {1'b0, p_q} : m_q;
  assign add_s = {1'b0, base} + {1'b0, hm};
  assign add_m = (add_s >= {1'b0, r_eff}) ? RW'(add_s - {1'b0, r_eff}) : add_s[RW-1:0];
  assign sub_m = (m_q >= hm) ? (m_q - hm) : (m_q + r_eff - hm);

  always_comb begin
    m_d   = m_q;
    cnt_d = cnt_q;
    if (cmd_i.init_down) begin
      m_d   = add_m;
      cnt_d = CW'(hop_q);
    end else if (cmd_i.step_down) begin
      m_d   = add_m;
      cnt_d = cnt_q + CW'(hop_q);
    end else if (cmd_i.init_up) begin
      m_d   = {1'b0, p_q};
      cnt_d = '0;
    end else if (cmd_i.step_up) begin
      m_d   = sub_m;
      cnt_d = cnt_q + CW'(hop_q);
    end
  end

  assign rd_en = (cmd_i.step_down || cmd_i.step_up) && (m_q < n_eff);
  assign wr_en = in_accept_i && (command_i == owb_pkg::CMD_WRITE) &&
                 (32'(position_i) < 32'(RING_DEPTH));

  assign raddr_wide = {{AW{1'b0}}, m_q};
  assign waddr_wide = {{AW{1'b0}}, position_i};
  assign wdata_wide = {{COEFF_BITS{1'b0}}, coefficient_i};

  owb_ram #(
    .WIDTH (COEFF_BITS),
    .DEPTH (RING_DEPTH)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr_wide[AW-1:0]),
    .wdata_i (wdata_wide[COEFF_BITS-1:0]),
    .re_i    (rd_en),
    .raddr_i (raddr_wide[AW-1:0]),
    .rdata_o (rdata)
  );

  assign sum_ext = {1'b0, sum_q} + {{(VW + 1 - COEFF_BITS){1'b0}}, rdata};

  always_comb begin
    sum_d = sum_q;
    if (cmd_i.load_query) begin
      sum_d = '0;
    end else if (pend_q) begin
      sum_d = sum_ext[VW] ? {VW{1'b1}} : sum_ext[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_query) begin
      p_q <= position_i;
    end
    m_q   <= m_d;
    cnt_q <= cnt_d;
    sum_q <= sum_d;
    if (cmd_i.load_out) begin
      norm_position_q <= p_q;
      norm_value_q    <= sum_q;
    end
  end

  assign norm_position_o = norm_position_q;
  assign norm_value_o    = norm_value_q;

endmodule

>>> hw/rtl/owb_ctrl.sv
module owb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 command_i,
  input  logic                 out_ready_i,
  input  logic                 cfg_we_i,
  input  owb_pkg::ctl_status_t status_i,
  output owb_pkg::ctl_cmd_t    cmd_o,
  output logic                 in_ready_o,
  output logic                 out_valid_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_HM,
    ST_DOWN,
    ST_UP,
    ST_FIN
  } state_e;

  state_e state_q, state_d;
  logic   hm_ok_q, hm_ok_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    hm_ok_d     = hm_ok_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (command_i == owb_pkg::CMD_QUERY)) begin
          cmd_o.load_query = 1'b1;
          state_d          = ST_PREP;
        end
      end
      ST_PREP: begin
        if (status_i.degenerate) begin
          state_d = ST_FIN;
        end else if (hm_ok_q) begin
          cmd_o.init_down = 1'b1;
          state_d         = ST_DOWN;
        end else begin
          cmd_o.hm_start = 1'b1;
          state_d        = ST_HM;
        end
      end
      ST_HM: begin
        if (!status_i.hm_busy) begin
          hm_ok_d         = 1'b1;
          cmd_o.init_down = 1'b1;
          state_d         = ST_DOWN;
        end
      end
      ST_DOWN: begin
        if (status_i.down_ok) begin
          cmd_o.step_down = 1'b1;
        end else begin
          cmd_o.init_up = 1'b1;
          state_d       = ST_UP;
        end
      end
      ST_UP: begin
        if (status_i.up_ok) begin
          cmd_o.step_up = 1'b1;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // The cached hop remainder belongs to the old ring and hop settings.
    if (cfg_we_i) begin
      hm_ok_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hm_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hm_ok_q     <= hm_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/ola_window_norm_builder.sv
// A coefficient write does not leave the idle state; the next transaction is accepted right after it.
// A query steps once per frame placement, descending and then ascending, before its result is loaded;
// a degenerate query skips the placements, and a result waits while the output register is full.
// The first full query after reset or a configuration write first runs the hop remainder unit.
// The next transaction is accepted the cycle after the result enters the output register.
// Reset (rst_ni low, asynchronous) restores default ring, frame and hop, not the window RAM.
module ola_window_norm_builder #(
  parameter int unsigned RING_DEPTH = owb_pkg::RING_DEPTH_DEF,
  parameter int unsigned COEFF_BITS = owb_pkg::COEFF_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [owb_pkg::POS_W-1:0]     position_i,
  input  logic [owb_pkg::COEF_W-1:0]    coefficient_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [owb_pkg::POS_W-1:0]     norm_position_o,
  output logic [owb_pkg::VALUE_W-1:0]   norm_value_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [owb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [owb_pkg::RING_W-1:0]    cfg_data_i
);

  owb_pkg::ctl_cmd_t    cmd;
  owb_pkg::ctl_status_t status;
  logic                 in_accept;
  logic                 cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign in_accept   = in_valid_i && in_ready_o;

  owb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o)
  );

  owb_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .COEFF_BITS (COEFF_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_accept_i     (in_accept),
    .command_i       (command_i),
    .position_i      (position_i),
    .coefficient_i   (coefficient_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .norm_position_o (norm_position_o),
    .norm_value_o    (norm_value_o)
  );

endmodule

>>> hw/rtl/owb_checker.sv
module owb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          command_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [owb_pkg::POS_W-1:0]     norm_position_o,
  input logic [owb_pkg::VALUE_W-1:0]   norm_value_o
);

  // A stalled result keeps its valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result valid dropped before the transaction completed");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(norm_position_o) && $stable(norm_value_o))
    else $error("result payload changed while stalled");

  // A coefficient write never creates a result.
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (command_i == owb_pkg::CMD_WRITE) && !out_valid_o
    |=> !out_valid_o)
    else $error("result appeared after a coefficient write");

  // A query occupies the block for at least the cycle after it is taken.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (command_i == owb_pkg::CMD_QUERY) |=> !in_ready_o)
    else $error("input ready right after a query transaction");

endmodule

bind ola_window_norm_builder owb_checker u_owb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .command_i       (command_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .norm_position_o (norm_position_o),
  .norm_value_o    (norm_value_o)
);
